[hw/rtl/mavg_pkg.sv]
// shared types for the moving average window block
`default_nettype none
package mavg_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } mavg_div_stat_t;

endpackage
`default_nettype wire

[hw/rtl/moving_average_window.sv]
// moving average window: top level joining sample queue and averaging engine
//
// usage:
//   input side is a queue: drive sample with push; a transaction completes on
//   a clock edge with push high and full low. up to two samples wait in the
//   front queue while the engine is busy.
//   result side is a queue: average is valid while empty is low and a
//   transaction completes on a clock edge with pop high and empty low.
//   every sample gives exactly one average, in order.
// timing:
//   the serial divider retires one quotient bit per cycle over the SUM_W
//   bits of the running sum, SUM_W being SAMPLE_BITS + clog2(WINDOW). samples
//   are handled one at a time: the engine takes no new sample until the
//   average of the last one is in the result register.
// reset:
//   synchronous rst empties both queues, clears the running sum, head and
//   fill count; the ring is treated as all zero until it has filled once.
// stall:
//   a held result keeps the engine waiting; the front queue keeps taking
//   samples until it has two, then full goes high.
`default_nettype none
module moving_average_window #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      average
);

  logic                          item_valid;
  logic signed [SAMPLE_BITS-1:0] item_sample;
  logic                          item_take;

  mavg_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .sample      (sample),
    .full        (full),
    .item_valid  (item_valid),
    .item_sample (item_sample),
    .item_take   (item_take)
  );

  mavg_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_sample (item_sample),
    .item_take   (item_take),
    .empty       (empty),
    .pop         (pop),
    .average     (average)
  );

endmodule
`default_nettype wire

[hw/rtl/mavg_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hw/rtl/mavg_front.sv]
// input side: two entry sample queue ahead of the averaging engine
`default_nettype none
module mavg_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               full,
  output logic                               item_valid,
  output logic signed [SAMPLE_BITS-1:0]      item_sample,
  input  wire logic                          item_take
);

  logic signed [SAMPLE_BITS-1:0] slot [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    count;
  logic                          do_push;
  logic                          do_pop;

  assign full        = (count == 2'd2);
  assign item_valid  = (count != 2'd0);
  assign item_sample = slot[rd_ptr];
  assign do_push     = push && !full;
  assign do_pop      = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= sample;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mavg_div.sv]
// serial restoring divider: signed running sum over the fill count
`default_nettype none
module mavg_div
  import mavg_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int SUM_W       = 19,
  parameter int CNT_W       = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [SUM_W-1:0]       dividend,
  input  wire logic [CNT_W-1:0]              divisor,
  output mavg_div_stat_t                     stat,
  output logic signed [SAMPLE_BITS-1:0]      quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic                   busy;
  logic                   done;
  logic [STEP_W-1:0]      step;
  logic                   neg;
  logic [SUM_W-1:0]       dq;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       dvs;
  logic [SUM_W-1:0]       mag;
  logic [CNT_W:0]         trial;
  logic                   ge;
  logic [CNT_W-1:0]       rem_next;
  logic [SAMPLE_BITS-1:0] qmag;

  assign mag      = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
  assign trial    = {rem, dq[SUM_W-1]};
  assign ge       = (trial >= {1'b0, dvs});
  assign rem_next = ge ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
  assign qmag     = dq[SAMPLE_BITS-1:0];
  assign quotient = neg ? -qmag : qmag;
  assign stat     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, shifted in at the bottom of dq
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      dq  <= mag;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[SUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/mavg_back.sv]
// averaging engine: sample ring, running sum, divide and result register
`default_nettype none
module mavg_back
  import mavg_pkg::*;
#(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] item_sample,
  output logic                               item_take,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      average
);

  localparam int HEAD_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_OUT
  } state_t;

  state_t                        state;
  logic [HEAD_W-1:0]             head;
  logic [HEAD_W-1:0]             head_next;
  logic [CNT_W-1:0]              fill_count;
  logic [CNT_W-1:0]              fill_count_next;
  logic signed [SUM_W-1:0]       window_sum;
  logic signed [SUM_W-1:0]       window_sum_next;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic [SAMPLE_BITS-1:0]        ring_rdata;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic                          ring_full;
  logic                          out_valid;
  logic                          out_pop;
  logic                          ring_we;
  logic                          div_start;
  mavg_div_stat_t                div_stat;
  logic signed [SAMPLE_BITS-1:0] div_quotient;

  assign item_take = (state == S_IDLE);
  assign ring_we   = (state == S_UPD);
  assign div_start = (state == S_UPD);
  assign empty     = !out_valid;
  assign out_pop   = pop && out_valid;
  assign ring_full = (fill_count == CNT_W'(WINDOW));

  // a slot is unwritten exactly while the ring is still filling
  assign old_sample = ring_full ? ring_rdata : '0;

  assign window_sum_next = window_sum - SUM_W'(old_sample) + SUM_W'(cur_sample);
  assign head_next       = (head == HEAD_W'(WINDOW - 1)) ? '0 : head + HEAD_W'(1);
  assign fill_count_next = ring_full ? fill_count : fill_count + CNT_W'(1);

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head),
    .wdata (cur_sample),
    .raddr (head),
    .rdata (ring_rdata)
  );

  mavg_div #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum_next),
    .divisor  (fill_count_next),
    .stat     (div_stat),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      fill_count <= '0;
      window_sum <= '0;
      out_valid  <= 1'b0;
      average    <= '0;
    end else begin
      // a new result may replace the one popped in the same cycle
      if (state == S_OUT && (!out_valid || out_pop)) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          window_sum <= window_sum_next;
          head       <= head_next;
          fill_count <= fill_count_next;
          state      <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_pop) begin
            average <= div_quotient;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      cur_sample <= item_sample;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(WINDOW))
    else $error("fill count above window");

  a_head_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !ring_full |-> (CNT_W'(head) == fill_count))
    else $error("head out of step with fill count while ring fills");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(average))
    else $error("waiting result lost or changed");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_div_after_upd: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |=> div_stat.busy)
    else $error("divider not started after sum update");

endmodule
`default_nettype wire

[verif/tb.sv]
// testbench for moving_average_window: directed table, random samples, predicted averages
`default_nettype none
module tb;

  localparam int WIN     = 8;
  localparam int N_RAND  = 1925;
  localparam int N_DIR   = 25;
  localparam int HOLD_CY = 400;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    logic signed [15:0] smp;
    bit                 known;
    logic signed [15:0] mean;
  } dir_row_t;

  // known means only where the ring contents are obvious
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{16'sh7fff, 1'b1, 16'sh7fff},
    '{16'sh8000, 1'b1, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b0, 16'sh0000},
    '{16'sh8000, 1'b1, 16'sh8000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b0, 16'sh0000},
    '{16'sh7fff, 1'b1, 16'sh7fff},
    '{16'sh0001, 1'b0, 16'sh0000},
    '{16'shffff, 1'b0, 16'sh0000},
    '{16'sh0000, 1'b0, 16'sh0000},
    '{16'sh5555, 1'b0, 16'sh0000},
    '{16'shaaaa, 1'b0, 16'sh0000},
    '{16'shfff9, 1'b0, 16'sh0000},
    '{16'sh0003, 1'b0, 16'sh0000}
  };

  logic               clk;
  logic               rst    = 1'b1;
  logic               push   = 1'b0;
  logic               pop    = 1'b0;
  logic signed [15:0] sample = '0;
  logic               full;
  logic               empty;
  logic signed [15:0] average;

  moving_average_window u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .sample  (sample),
    .empty   (empty),
    .pop     (pop),
    .average (average)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // predictor state
  logic signed [15:0] held_samples [WIN];
  logic [2:0]         head_pos;
  logic [3:0]         fill_cnt;
  logic signed [18:0] run_sum;

  logic signed [15:0] expected_means [$];
  int samples_sent;
  int means_checked;
  int mismatches;
  int full_stalls;
  int burst_left;

  function automatic logic signed [15:0] next_mean(input logic signed [15:0] s);
    logic signed [31:0] q;
    run_sum = run_sum - held_samples[head_pos] + s;
    held_samples[head_pos] = s;
    head_pos = head_pos + 3'd1;
    if (fill_cnt < WIN) fill_cnt = fill_cnt + 4'd1;
    q = run_sum / $signed({1'b0, fill_cnt});
    return q[15:0];
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one sample, wait for the transaction, then idle between bursts
  task automatic offer(input logic signed [15:0] s, input bit known,
                       input logic signed [15:0] typed);
    logic signed [15:0] m;
    push <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (full) begin
      full_stalls++;
      @(posedge clk);
    end
    m = next_mean(s);
    expected_means.push_back(known ? typed : m);
    samples_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      push <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(0, 15);
    end
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) held_samples[i] = '0;
    head_pos      = '0;
    fill_cnt      = '0;
    run_sum       = '0;
    samples_sent  = 0;
    means_checked = 0;
    mismatches    = 0;
    full_stalls   = 0;
    burst_left    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_DIR; i++)
      offer(DIRECTED[i].smp, DIRECTED[i].known, DIRECTED[i].mean);
    for (int i = 0; i < N_RAND; i++)
      offer(pick_sample(), 1'b0, 16'sh0000);
    push <= 1'b0;
    while (expected_means.size() != 0) @(posedge clk);
    // any stray average would show up here
    repeat (60) @(posedge clk);
    $display("covered %0d samples (%0d directed), %0d averages checked",
             samples_sent, N_DIR, means_checked);
    $display("input held off by full for %0d cycles", full_stalls);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: check each transaction, pop on a changing pattern
  initial begin : drain
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       rx_cyc;
    bit       first_hold_done;
    bit       second_hold_done;
    logic signed [15:0] want;
    mode             = RX_FREE;
    mode_left        = 0;
    hold_left        = 0;
    rx_cyc           = 0;
    first_hold_done  = 1'b0;
    second_hold_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (expected_means.size() == 0) begin
          $error("average with no sample pending: got %0d", average);
          mismatches++;
        end else begin
          want = expected_means.pop_front();
          if (average !== want) begin
            $error("average mismatch: expected %0d, got %0d", want, average);
            mismatches++;
          end
          means_checked++;
        end
      end
      rx_cyc++;
      // long hold-off so the front queue fills and full rises
      if (hold_left == 0 && !first_hold_done && means_checked >= 30) begin
        first_hold_done = 1'b1;
        hold_left = HOLD_CY;
      end else if (hold_left == 0 && !second_hold_done && means_checked >= 1200) begin
        second_hold_done = 1'b1;
        hold_left = HOLD_CY;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          RX_FREE:   pop <= 1'b1;
          RX_COIN:   pop <= 1'($urandom_range(0, 1));
          RX_SPARSE: pop <= (rx_cyc % 8) == 0;
          default:   pop <= rx_cyc[2];
        endcase
      end
    end
  end

endmodule
`default_nettype wire

[sim.f]
hw/rtl/mavg_pkg.sv
hw/rtl/mavg_ram.sv
hw/rtl/mavg_front.sv
hw/rtl/mavg_div.sv
hw/rtl/mavg_back.sv
hw/rtl/moving_average_window.sv
verif/tb.sv
